[design/pdset_pkg.sv]
// ----------------------------------------------------------------------------
// pdset_pkg
// Shared constants and types for the prefix hash duplicate detector.
// ----------------------------------------------------------------------------
package pdset_pkg;

  // Table depth. The home slot is taken from the low hash bits, so the depth
  // is kept a power of two.
  localparam int SLOTS = 1024;
  localparam int IDX_W = $clog2(SLOTS);

  localparam int HASH_W  = 64;
  localparam int BYTES_W = 64;
  localparam int LEN_W   = 4;

  localparam logic [HASH_W-1:0] HASH_BASIS = 64'hcbf29ce484222325;
  // The prime is 2^40 + 0x1b3: a shift plus a narrow constant multiply.
  localparam int                PRIME_SHIFT = 40;
  localparam logic [8:0]        PRIME_LO    = 9'h1b3;
  localparam logic [LEN_W-1:0]  MAX_LEN     = 4'd8;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_RD    = 6'b001000,
    S_CMP   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

endpackage

[design/pdset_hasher.sv]
// ----------------------------------------------------------------------------
// pdset_hasher
// Iterative FNV-1a hash over up to eight bytes, one byte per cycle through a
// single shift-and-multiply step.
// ----------------------------------------------------------------------------
module pdset_hasher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pdset_pkg::BYTES_W-1:0] bytes_in,
  input  logic [pdset_pkg::LEN_W-1:0]   len_in,
  output logic                          done,
  output logic [pdset_pkg::HASH_W-1:0]  hash
);

  logic                          busy_r, busy_nxt;
  logic [pdset_pkg::LEN_W-1:0]   cnt_r, cnt_nxt;
  logic [pdset_pkg::HASH_W-1:0]  h_r, h_nxt;
  logic [pdset_pkg::BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [pdset_pkg::HASH_W-1:0]  mix;
  logic [pdset_pkg::HASH_W-1:0]  prod;

  assign mix  = h_r ^ {{(pdset_pkg::HASH_W-8){1'b0}}, bytes_r[7:0]};
  assign prod = pdset_pkg::HASH_W'(mix * pdset_pkg::PRIME_LO);

  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    h_nxt     = h_r;
    bytes_nxt = bytes_r;
    if (start) begin
      busy_nxt  = 1'b1;
      h_nxt     = pdset_pkg::HASH_BASIS;
      bytes_nxt = bytes_in;
      cnt_nxt   = (len_in > pdset_pkg::MAX_LEN) ? pdset_pkg::MAX_LEN : len_in;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        h_nxt     = (mix << pdset_pkg::PRIME_SHIFT) + prod;
        bytes_nxt = bytes_r >> 8;
        cnt_nxt   = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    h_r     <= h_nxt;
    bytes_r <= bytes_nxt;
  end

  assign done = busy_r && (cnt_r == '0);
  assign hash = h_r;

endmodule

[design/prefix_hash_dedup_set_core.sv]
// ----------------------------------------------------------------------------
// prefix_hash_dedup_set_core
// Hashes a line prefix and inserts the hash into a linear-probe set table,
// reporting whether the line is new.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Word
//  in_     | input     | in_valid/in_stall  | prefix_bytes, prefix_len
//  out_    | output    | out_valid/out_stall| is_new, overwrote_full
//
//  Each item hashes min(len,8) bytes, then makes 1 to SLOTS table probes through
//  the single read port, each probe a read (S_RD) and a compare (S_CMP).
//  After reset a clearing pass writes zero to all SLOTS entries while in_stall is high.
//  The result sits in an output register; the block returns to idle once the
//  result is loaded there, so a stalled result delays at most one next item.
// ----------------------------------------------------------------------------
module prefix_hash_dedup_set_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pdset_pkg::BYTES_W-1:0] in_prefix_bytes,
  input  logic [pdset_pkg::LEN_W-1:0]   in_prefix_len,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_new,
  output logic                          out_overwrote_full
);

  pdset_pkg::state_t state_r, state_nxt;

  logic [pdset_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [pdset_pkg::IDX_W-1:0]  probe_r, probe_nxt;
  logic                         res_new_r, res_new_nxt;
  logic                         res_full_r, res_full_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_is_new_r, out_is_new_nxt;
  logic                         out_full_r, out_full_nxt;

  logic [pdset_pkg::HASH_W-1:0] mem [pdset_pkg::SLOTS];
  logic [pdset_pkg::HASH_W-1:0] rdata_r;
  logic                         mem_we;
  logic [pdset_pkg::IDX_W-1:0]  mem_waddr;
  logic [pdset_pkg::HASH_W-1:0] mem_wdata;

  logic                         in_accept;
  logic                         hash_done;
  logic [pdset_pkg::HASH_W-1:0] hash;
  logic [pdset_pkg::IDX_W-1:0]  home;
  logic                         out_free;

  assign in_stall  = (state_r != pdset_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign home      = hash[pdset_pkg::IDX_W-1:0];
  assign out_free  = !out_valid_r || !out_stall;

  pdset_hasher u_hasher (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_accept),
    .bytes_in (in_prefix_bytes),
    .len_in   (in_prefix_len),
    .done     (hash_done),
    .hash     (hash)
  );

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    probe_nxt      = probe_r;
    res_new_nxt    = res_new_r;
    res_full_nxt   = res_full_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_is_new_nxt = out_is_new_r;
    out_full_nxt   = out_full_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = hash;
    case (state_r)
      pdset_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == pdset_pkg::IDX_W'(pdset_pkg::SLOTS - 1)) begin
          state_nxt = pdset_pkg::S_IDLE;
        end
      end
      pdset_pkg::S_IDLE: begin
        if (in_accept) begin
          state_nxt = pdset_pkg::S_HASH;
        end
      end
      pdset_pkg::S_HASH: begin
        if (hash_done) begin
          idx_nxt   = home;
          probe_nxt = '0;
          state_nxt = pdset_pkg::S_RD;
        end
      end
      pdset_pkg::S_RD: begin
        state_nxt = pdset_pkg::S_CMP;
      end
      pdset_pkg::S_CMP: begin
        if (rdata_r == '0) begin
          mem_we       = 1'b1;
          res_new_nxt  = 1'b1;
          res_full_nxt = 1'b0;
          state_nxt    = pdset_pkg::S_DONE;
        end else if (rdata_r == hash) begin
          res_new_nxt  = 1'b0;
          res_full_nxt = 1'b0;
          state_nxt    = pdset_pkg::S_DONE;
        end else if (probe_r == pdset_pkg::IDX_W'(pdset_pkg::SLOTS - 1)) begin
          mem_we       = 1'b1;
          mem_waddr    = home;
          res_new_nxt  = 1'b1;
          res_full_nxt = 1'b1;
          state_nxt    = pdset_pkg::S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          probe_nxt = probe_r + 1'b1;
          state_nxt = pdset_pkg::S_RD;
        end
      end
      pdset_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_is_new_nxt = res_new_r;
          out_full_nxt   = res_full_r;
          state_nxt      = pdset_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pdset_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pdset_pkg::S_CLEAR;
      idx_r       <= '0;
      probe_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      probe_r     <= probe_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_new_r    <= res_new_nxt;
    res_full_r   <= res_full_nxt;
    out_is_new_r <= out_is_new_nxt;
    out_full_r   <= out_full_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[idx_r];
  end

  assign out_valid          = out_valid_r;
  assign out_is_new         = out_is_new_r;
  assign out_overwrote_full = out_full_r;

endmodule

[design/pdset_checker.sv]
// ----------------------------------------------------------------------------
// pdset_checker
// Port-level checks on the duplicate detector, bound to the top level.
// ----------------------------------------------------------------------------
module pdset_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_is_new,
  input logic out_overwrote_full
);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_is_new)
      && $stable(out_overwrote_full))
    else $error("stalled result word changed");

  // An accepted word keeps the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accept");

  // An overwrite of a full table is always reported as an insertion.
  a_full_is_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overwrote_full |-> out_is_new)
    else $error("overwrite flagged on a duplicate");

  // Reset leaves no result pending and the table clearing under way.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("block not quiet after reset");

endmodule

bind prefix_hash_dedup_set_core pdset_checker u_pdset_checker (.*);

[bench/tb_prefix_hash_dedup_set_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_prefix_hash_dedup_set_core
// Self-checking bench for the prefix hash duplicate detector. A queue-fed
// driver offers line prefixes with random gaps, and a monitor applies random
// stalls. Every accepted word is run through a local FNV-1a hash and a
// linear-probe set table to predict whether the line is new. Stimulus covers
// directed corner lines, a long mixed run of fresh and repeated lines, and a
// fill phase that packs the table and then forces home-slot overwrites.
// ----------------------------------------------------------------------------
module tb_prefix_hash_dedup_set_core;

  localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME  = 64'h00000100000001b3;
  localparam int          TABLE_SIZE = pdset_pkg::SLOTS;

  typedef struct {
    logic [63:0] bytes;
    logic [3:0]  len;
  } line_t;

  typedef struct {
    logic is_new;
    logic overwrote_full;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_prefix_bytes = '0;
  logic [3:0]  in_prefix_len = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_is_new;
  logic        out_overwrote_full;

  line_t       pending_lines[$];
  line_t       sent_lines[$];
  verdict_t    verdict_q[$];
  logic [63:0] slot_words[TABLE_SIZE];
  int          occupied = 0;
  line_t       next_line;
  int          in_gap = 0;
  int          out_hold = 0;
  bit          calm = 1'b0;
  bit          failed = 1'b0;

  prefix_hash_dedup_set_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_prefix_bytes    (in_prefix_bytes),
    .in_prefix_len      (in_prefix_len),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_is_new         (out_is_new),
    .out_overwrote_full (out_overwrote_full)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] line_hash(input logic [63:0] bytes, input logic [3:0] len);
    logic [63:0] acc;
    int          n;
    acc = FNV_OFFSET;
    n = (len > 4'd8) ? 8 : int'(len);
    for (int i = 0; i < n; i++) begin
      acc = acc ^ {56'd0, bytes[8*i +: 8]};
      acc = acc * FNV_PRIME;
    end
    return acc;
  endfunction

  function automatic int unsigned home_slot(input logic [63:0] h);
    return int'(h % 64'(TABLE_SIZE));
  endfunction

  task automatic insert_line(input logic [63:0] bytes, input logic [3:0] len);
    logic [63:0] h;
    int unsigned home;
    int unsigned idx;
    int          probes;
    verdict_t    v;
    bit          settled;
    h = line_hash(bytes, len);
    home = home_slot(h);
    idx = home;
    settled = 1'b0;
    v.is_new = 1'b1;
    v.overwrote_full = 1'b1;
    for (probes = 0; probes < TABLE_SIZE && !settled; probes++) begin
      if (slot_words[idx] == 64'd0) begin
        slot_words[idx] = h;
        if (h != 64'd0) occupied++;
        v.overwrote_full = 1'b0;
        settled = 1'b1;
      end else if (slot_words[idx] == h) begin
        v.is_new = 1'b0;
        v.overwrote_full = 1'b0;
        settled = 1'b1;
      end else begin
        idx = (idx + 1 == TABLE_SIZE) ? 0 : idx + 1;
      end
    end
    if (!settled) slot_words[home] = h;
    verdict_q = {verdict_q, v};
  endtask

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) insert_line(in_prefix_bytes, in_prefix_len);
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_lines.size() != 0) begin
          next_line = pending_lines.pop_front();
          in_valid <= 1'b1;
          in_prefix_bytes <= next_line.bytes;
          in_prefix_len <= next_line.len;
          in_gap <= pick_gap();
          if ($urandom_range(0, 39) == 0) calm <= ~calm;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected word: is_new=%0b overwrote_full=%0b", out_is_new, out_overwrote_full);
        failed = 1'b1;
      end else begin
        want = verdict_q.pop_front();
        if (out_is_new !== want.is_new) begin
          $error("is_new: expected %0b, actual %0b", want.is_new, out_is_new);
          failed = 1'b1;
        end
        if (out_overwrote_full !== want.overwrote_full) begin
          $error("overwrote_full: expected %0b, actual %0b", want.overwrote_full,
                 out_overwrote_full);
          failed = 1'b1;
        end
      end
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold <= 0;
    end else if (out_hold != 0) begin
      out_stall <= 1'b1;
      out_hold <= out_hold - 1;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 3) == 0) out_hold <= pick_gap();
    end
  end

  task automatic queue_line(input logic [63:0] bytes, input logic [3:0] len);
    line_t l;
    l.bytes = bytes;
    l.len = len;
    pending_lines = {pending_lines, l};
    sent_lines = {sent_lines, l};
  endtask

  function automatic logic [63:0] line_with_home(input int unsigned target);
    logic [63:0] bytes;
    do begin
      bytes = {$urandom, $urandom};
    end while (home_slot(line_hash(bytes, 4'd8)) != target);
    return bytes;
  endfunction

  task automatic wait_idle();
    while (pending_lines.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    #200_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    line_t       old;
    logic [63:0] keep;
    logic [3:0]  len;
    int          r;
    int          fresh;
    int unsigned homes[5];

    for (int i = 0; i < TABLE_SIZE; i++) slot_words[i] = 64'd0;
    homes = '{TABLE_SIZE - 1, TABLE_SIZE - 1, 0, 7, 7};

    // Directed lines: byte extremes, zero and oversized lengths, ignored upper
    // bytes, every length from 1 to 8, and lines that share a home slot or wrap around.
    queue_line(64'd0, 4'd1);
    queue_line('1, 4'd8);
    queue_line('1, 4'd8);
    queue_line(64'd0, 4'd0);
    queue_line(64'h5a5a_0f0f_3c3c_9696, 4'd0);
    queue_line('1, 4'd15);
    queue_line('1, 4'd9);
    for (int n = 1; n <= 8; n++) queue_line(64'h0123_4567_89ab_cdef, 4'(n));
    queue_line({40'hff_ffff_ffff, 24'habcdef}, 4'd3);
    foreach (homes[k]) queue_line(line_with_home(homes[k]), 4'd8);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 650; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        old = sent_lines[$urandom_range(0, sent_lines.size() - 1)];
        keep = (old.len >= 4'd8) ? '1 : ((64'd1 << (8 * old.len)) - 64'd1);
        len = (old.len >= 4'd8) ? 4'($urandom_range(8, 15)) : old.len;
        queue_line((old.bytes & keep) | ({$urandom, $urandom} & ~keep), len);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 85) len = 4'($urandom_range(1, 8));
        else if (r < 93) len = 4'd0;
        else len = 4'($urandom_range(9, 15));
        queue_line({$urandom, $urandom}, len);
      end
    end

    wait_idle();

    fresh = TABLE_SIZE - occupied + 4;
    for (int i = 0; i < fresh; i++) queue_line({$urandom, $urandom}, 4'd8);
    for (int i = 0; i < 16; i++) begin
      if (i % 2 == 0) begin
        queue_line({$urandom, $urandom}, 4'd8);
      end else begin
        old = sent_lines[$urandom_range(sent_lines.size() - 20, sent_lines.size() - 1)];
        queue_line(old.bytes, old.len);
      end
    end

    wait_idle();
    repeat (2 * TABLE_SIZE + 16) @(posedge clk);

    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
